>>> rtl/imu_complementary_filter_assert.svh
// Assertion macros used by the complementary filter top level.
`ifndef IMU_COMPLEMENTARY_FILTER_ASSERT_SVH
`define IMU_COMPLEMENTARY_FILTER_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define ICF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define ICF_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/icf_pkg.sv
// Types, constants and the arctangent table of the complementary filter.
package icf_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ANGLE_FRAC_BITS_DEF   = 16;

    localparam int ATAN_FRAC       = 24;
    localparam int ATAN_LEN        = 24;
    localparam int ATAN_IDX_W      = 5;
    localparam int ATAN_W          = 31;
    localparam int IN_SHIFT        = 20;
    localparam int RESET_ANGLE_DEG = 200;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_LOW     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_HIGH    = 2'd3;

    localparam logic [15:0] GYRO_SCALE_RST   = 16'd10;
    localparam logic [16:0] BLEND_WEIGHT_RST = 17'd64225;
    localparam logic [16:0] GATE_LOW_RST     = 17'd8192;
    localparam logic [16:0] GATE_HIGH_RST    = 17'd32768;
    localparam logic [16:0] BLEND_ONE        = 17'd65536;

    typedef struct packed {
        logic signed [15:0] gyro_rate_x;
        logic signed [15:0] gyro_rate_y;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] pitch_out;
        logic signed [31:0] roll_out;
        logic               accel_applied;
    } angle_t;

    typedef struct packed {
        logic load;
        logic gyro;
        logic cinit;
        logic citer;
        logic mul_old;
        logic mul_new;
        logic finish;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic applied;
        logic iter_last;
    } dp_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GYRO,
        ST_CINIT,
        ST_CITER,
        ST_MUL_OLD,
        ST_MUL_NEW,
        ST_FINISH,
        ST_DELIVER
    } icf_state_t;

    // atan(2^-i) in degrees with ATAN_FRAC fraction bits.
    function automatic logic [ATAN_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] i);
        logic [ATAN_W-1:0] v;
        unique case (i)
            5'd0:    v = 31'd754974720;
            5'd1:    v = 31'd445687602;
            5'd2:    v = 31'd235489088;
            5'd3:    v = 31'd119537938;
            5'd4:    v = 31'd60000934;
            5'd5:    v = 31'd30029717;
            5'd6:    v = 31'd15018523;
            5'd7:    v = 31'd7509720;
            5'd8:    v = 31'd3754917;
            5'd9:    v = 31'd1877466;
            5'd10:   v = 31'd938734;
            5'd11:   v = 31'd469367;
            5'd12:   v = 31'd234684;
            5'd13:   v = 31'd117342;
            5'd14:   v = 31'd58671;
            5'd15:   v = 31'd29335;
            5'd16:   v = 31'd14668;
            5'd17:   v = 31'd7334;
            5'd18:   v = 31'd3667;
            5'd19:   v = 31'd1833;
            5'd20:   v = 31'd917;
            5'd21:   v = 31'd458;
            5'd22:   v = 31'd229;
            5'd23:   v = 31'd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/icf_ctrl.sv
// Sequencer of the complementary filter: steps the datapath through one sample.
module icf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    output logic                angle_valid,
    input  logic                angle_stall,
    input  icf_pkg::dp_status_t status,
    output icf_pkg::dp_cmd_t    cmd
);
    import icf_pkg::*;

    icf_state_t state_reg, state_next;
    logic       valid_reg, valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        valid_next = valid_reg;
        if (valid_reg && !angle_stall)
        begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_GYRO;
                end
            end
            ST_GYRO:
            begin
                cmd.gyro   = 1'b1;
                state_next = status.applied ? ST_CINIT : ST_DELIVER;
            end
            ST_CINIT:
            begin
                cmd.cinit  = 1'b1;
                state_next = ST_CITER;
            end
            ST_CITER:
            begin
                cmd.citer = 1'b1;
                if (status.iter_last)
                begin
                    state_next = ST_MUL_OLD;
                end
            end
            ST_MUL_OLD:
            begin
                cmd.mul_old = 1'b1;
                state_next  = ST_MUL_NEW;
            end
            ST_MUL_NEW:
            begin
                cmd.mul_new = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                // The output register is loaded only once the previous result is gone.
                if (!valid_reg || !angle_stall)
                begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign angle_valid  = valid_reg;

endmodule

>>> rtl/icf_datapath.sv
// Datapath of the complementary filter: registers, gyro step, two-lane CORDIC, blend.
module icf_datapath #(
    parameter int CORDIC_ITERATIONS = icf_pkg::CORDIC_ITERATIONS_DEF,
    parameter int ANGLE_FRAC_BITS   = icf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [icf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [icf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  icf_pkg::sample_t                    sample,
    input  icf_pkg::dp_cmd_t                    cmd,
    output icf_pkg::dp_status_t                 status,
    output icf_pkg::angle_t                     angle
);
    import icf_pkg::*;

    localparam int NITER = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;
    localparam int IT_W  = (NITER > 1) ? $clog2(NITER) : 1;
    localparam int GY_UP = (ANGLE_FRAC_BITS >= 16) ? ANGLE_FRAC_BITS - 16 : 0;
    localparam int GY_DN = (ANGLE_FRAC_BITS < 16) ? 16 - ANGLE_FRAC_BITS : 0;
    localparam int Z_DN  = ATAN_FRAC - ANGLE_FRAC_BITS;
    localparam int PW    = 40;
    localparam int XW    = 40;
    localparam int ZW    = 34;
    localparam int AW    = 52;

    localparam logic [PW-1:0] GY_RND = PW'((64'd1 << GY_DN) >> 1);
    localparam logic [ZW-1:0] Z_RND  = ZW'((64'd1 << Z_DN) >> 1);
    localparam logic [ZW-1:0] Z_QUARTER = ZW'(64'd90 << ATAN_FRAC);
    localparam logic [AW-1:0] BLEND_RND = AW'(64'd32768);
    localparam logic [31:0] ANGLE_RESET = 32'(64'(RESET_ANGLE_DEG) << ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] S32_MAX = AW'(64'sd2147483647);
    localparam logic signed [AW-1:0] S32_MIN = AW'(-64'sd2147483648);
    localparam logic [IT_W-1:0] IT_LAST = IT_W'(NITER - 1);

    function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
        begin
            r = S32_MAX[31:0];
        end
        else if (v < S32_MIN)
        begin
            r = S32_MIN[31:0];
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        return v[15] ? 17'(-e) : 17'(e);
    endfunction

    // Configuration registers.
    logic [15:0] gyro_scale_reg;
    logic [16:0] blend_weight_reg;
    logic [16:0] gate_low_reg;
    logic [16:0] gate_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_scale_reg   <= GYRO_SCALE_RST;
            blend_weight_reg <= BLEND_WEIGHT_RST;
            gate_low_reg     <= GATE_LOW_RST;
            gate_high_reg    <= GATE_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GYRO_SCALE:   gyro_scale_reg   <= cfg_data[15:0];
                REG_BLEND_WEIGHT: blend_weight_reg <= cfg_data;
                REG_GATE_LOW:     gate_low_reg     <= cfg_data;
                REG_GATE_HIGH:    gate_high_reg    <= cfg_data;
                default:          gyro_scale_reg   <= gyro_scale_reg;
            endcase
        end
    end

    sample_t            sample_reg;
    logic signed [31:0] pitch_reg, pitch_next;
    logic signed [31:0] roll_reg, roll_next;
    logic               applied_reg;
    angle_t             angle_reg;
    logic [IT_W-1:0]    it_reg;

    // Lane 0 resolves pitch from atan2(ay, az), lane 1 roll from atan2(ax, az).
    logic signed [XW-1:0] cx_reg [2];
    logic signed [XW-1:0] cy_reg [2];
    logic signed [ZW-1:0] cz_reg [2];
    logic                 zero_reg [2];
    logic signed [31:0]   ang_reg [2];
    logic signed [AW-1:0] acc_reg [2];

    // Gyro integration.
    logic signed [32:0]   prod_x, prod_y;
    logic signed [PW-1:0] delta_p, delta_r;
    logic [16:0]          mag;
    logic                 gate_ok;

    assign prod_x  = $signed(sample_reg.gyro_rate_x) * $signed({1'b0, gyro_scale_reg});
    assign prod_y  = $signed(sample_reg.gyro_rate_y) * $signed({1'b0, gyro_scale_reg});
    assign delta_p = ((PW'(prod_x) <<< GY_UP) + $signed(GY_RND)) >>> GY_DN;
    assign delta_r = ((PW'(prod_y) <<< GY_UP) + $signed(GY_RND)) >>> GY_DN;

    assign mag = abs16(sample_reg.accel_x) + abs16(sample_reg.accel_y)
               + abs16(sample_reg.accel_z);
    assign gate_ok = (mag > gate_low_reg) && (mag < gate_high_reg);

    // Blend weight above one keeps the old angle.
    logic [16:0] w_eff;
    assign w_eff = (blend_weight_reg > BLEND_ONE) ? BLEND_ONE : blend_weight_reg;

    // CORDIC lane logic and the lane multipliers.
    logic signed [XW-1:0] ini_x [2];
    logic signed [XW-1:0] ini_y [2];
    logic signed [ZW-1:0] ini_z [2];
    logic                 ini_zero [2];
    logic signed [XW-1:0] it_x [2];
    logic signed [XW-1:0] it_y [2];
    logic signed [ZW-1:0] it_z [2];
    logic signed [31:0]   z_round [2];
    logic signed [17:0]   mul_a [2];
    logic signed [31:0]   mul_b [2];
    logic signed [AW-1:0] mul_p [2];
    logic signed [15:0]   y_src [2];
    logic signed [31:0]   old_ang [2];
    logic signed [XW-1:0] xs, ys, dxs, dys;
    logic signed [ZW-1:0] step;

    assign y_src[0]   = sample_reg.accel_y;
    assign y_src[1]   = sample_reg.accel_x;
    assign old_ang[0] = pitch_reg;
    assign old_ang[1] = roll_reg;
    assign step       = $signed(ZW'(atan_deg(ATAN_IDX_W'(it_reg))));

    always_comb
    begin
        xs  = '0;
        ys  = '0;
        dxs = '0;
        dys = '0;
        for (int l = 0; l < 2; l++)
        begin
            xs          = XW'(sample_reg.accel_z) <<< IN_SHIFT;
            ys          = XW'(y_src[l]) <<< IN_SHIFT;
            ini_zero[l] = (sample_reg.accel_z == '0) && (y_src[l] == '0);
            // A vector in the left half plane is first turned by a quarter turn.
            if (sample_reg.accel_z[15])
            begin
                if (!y_src[l][15])
                begin
                    ini_x[l] = ys;
                    ini_y[l] = -xs;
                    ini_z[l] = $signed(Z_QUARTER);
                end
                else
                begin
                    ini_x[l] = -ys;
                    ini_y[l] = xs;
                    ini_z[l] = -$signed(Z_QUARTER);
                end
            end
            else
            begin
                ini_x[l] = xs;
                ini_y[l] = ys;
                ini_z[l] = '0;
            end

            dxs = cy_reg[l] >>> it_reg;
            dys = cx_reg[l] >>> it_reg;
            if (!cy_reg[l][XW-1])
            begin
                it_x[l] = cx_reg[l] + dxs;
                it_y[l] = cy_reg[l] - dys;
                it_z[l] = cz_reg[l] + step;
            end
            else
            begin
                it_x[l] = cx_reg[l] - dxs;
                it_y[l] = cy_reg[l] + dys;
                it_z[l] = cz_reg[l] - step;
            end

            z_round[l] = zero_reg[l] ? '0 : 32'((cz_reg[l] + $signed(Z_RND)) >>> Z_DN);

            if (cmd.mul_old)
            begin
                mul_a[l] = $signed({1'b0, w_eff});
                mul_b[l] = old_ang[l];
            end
            else
            begin
                mul_a[l] = $signed({1'b0, 17'(BLEND_ONE - w_eff)});
                mul_b[l] = ang_reg[l];
            end
            mul_p[l] = AW'(mul_a[l]) * AW'(mul_b[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
        end
        for (int l = 0; l < 2; l++)
        begin
            if (cmd.cinit)
            begin
                cx_reg[l]   <= ini_x[l];
                cy_reg[l]   <= ini_y[l];
                cz_reg[l]   <= ini_z[l];
                zero_reg[l] <= ini_zero[l];
            end
            else if (cmd.citer)
            begin
                cx_reg[l] <= it_x[l];
                cy_reg[l] <= it_y[l];
                cz_reg[l] <= it_z[l];
            end
            if (cmd.mul_old)
            begin
                ang_reg[l] <= z_round[l];
                acc_reg[l] <= mul_p[l];
            end
            else if (cmd.mul_new)
            begin
                acc_reg[l] <= acc_reg[l] + mul_p[l];
            end
        end
        if (cmd.gyro)
        begin
            applied_reg <= gate_ok;
        end
        if (cmd.out_load)
        begin
            angle_reg.pitch_out     <= pitch_reg;
            angle_reg.roll_out      <= roll_reg;
            angle_reg.accel_applied <= applied_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_reg <= '0;
        end
        else if (cmd.cinit)
        begin
            it_reg <= '0;
        end
        else if (cmd.citer && (it_reg != IT_LAST))
        begin
            it_reg <= it_reg + 1'b1;
        end
    end

    always_comb
    begin
        pitch_next = pitch_reg;
        roll_next  = roll_reg;
        if (cmd.gyro)
        begin
            pitch_next = sat32(AW'(pitch_reg) + AW'(delta_p));
            roll_next  = sat32(AW'(roll_reg) - AW'(delta_r));
        end
        else if (cmd.finish)
        begin
            pitch_next = sat32((acc_reg[0] + $signed(BLEND_RND)) >>> 16);
            roll_next  = sat32((acc_reg[1] + $signed(BLEND_RND)) >>> 16);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= ANGLE_RESET;
            roll_reg  <= ANGLE_RESET;
        end
        else
        begin
            pitch_reg <= pitch_next;
            roll_reg  <= roll_next;
        end
    end

    assign status.applied   = gate_ok;
    assign status.iter_last = (it_reg == IT_LAST);
    assign angle            = angle_reg;

endmodule

>>> rtl/imu_complementary_filter.sv
// Top level of the pitch and roll complementary filter.
// One IMU sample is taken at a time. Every sample first integrates the gyro rates into
// the held pitch and roll angles; when |ax|+|ay|+|az| lies strictly between gate_low and
// gate_high, a two-lane iterative CORDIC finds both accelerometer angles at once and each
// angle is blended toward its accelerometer angle by a shared per-lane multiplier. A
// corrected sample is loaded in idle and then steps through the gyro, CORDIC init, CORDIC
// iteration, old and new blend multiply, finish and deliver states; a sample that fails
// the gate goes from the gyro state straight to delivery. The next sample is accepted on the cycle after the result
// is loaded, even while that result still waits to be taken. Angles are signed fixed
// point with ANGLE_FRAC_BITS fraction bits and reset to 200 degrees.
`include "imu_complementary_filter_assert.svh"

module imu_complementary_filter #(
    parameter int CORDIC_ITERATIONS = icf_pkg::CORDIC_ITERATIONS_DEF,
    parameter int ANGLE_FRAC_BITS   = icf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [icf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [icf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  icf_pkg::sample_t                sample,
    output logic                            angle_valid,
    input  logic                            angle_stall,
    output icf_pkg::angle_t                 angle
);
    import icf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    icf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .angle_valid  (angle_valid),
        .angle_stall  (angle_stall),
        .status       (status),
        .cmd          (cmd)
    );

    icf_datapath #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .status    (status),
        .angle     (angle)
    );

    // A transaction on the input side always makes the block busy on the next cycle.
    `ICF_ASSERT(a_busy_after_accept, (sample_valid && !sample_stall) |=> sample_stall, "not busy")
    // The controller issues at most one datapath command per cycle.
    `ICF_ASSERT(a_cmd_onehot, $onehot0(cmd), "overlapping datapath commands")
    // A pending result is never overwritten.
    `ICF_ASSERT_NEVER(a_no_overwrite, cmd.out_load && angle_valid && angle_stall, "overwrite")
    // The CORDIC only starts when the accelerometer gate passed.
    `ICF_ASSERT(a_cordic_gated, cmd.cinit |-> status.applied, "CORDIC started without gate")

endmodule

>>> bench/tb.sv
// Self-checking testbench for the pitch and roll complementary filter.
module tb;
    import icf_pkg::*;

    localparam int     CYCLE_LIMIT   = 600000;
    localparam int     CORDIC_STEPS  = CORDIC_ITERATIONS_DEF;
    localparam int     PHASES        = 8;
    localparam int     PHASE_ITEMS   = 150;
    localparam int     SETTLE_CYCLES = 30;
    localparam longint ANGLE_MAX     = 64'sd2147483647;
    localparam longint ANGLE_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic        is_cfg;
        logic [16:0] gs;
        logic [16:0] bw;
        logic [16:0] gl;
        logic [16:0] gh;
        sample_t     s;
        logic        known;
        angle_t      want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  sample_valid;
    logic                  sample_stall;
    sample_t               sample;
    logic                  angle_valid;
    logic                  angle_stall = 1'b0;
    angle_t                angle;

    // Filter state and register copies kept by the predictor.
    longint pitch_q;
    longint roll_q;
    longint gyro_scale_q;
    longint blend_q;
    longint gate_low_q;
    longint gate_high_q;

    // atan(2^-i) in degrees, 24 fraction bits.
    longint atan_q24 [0:15] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335
    };

    angle_t    angle_q[$];
    stim_row_t stim_rows[$];
    logic      row_has_answer;
    angle_t    row_answer;
    int        idle_pct;
    int        stall_pct;
    int        mismatches;
    int        cycles;

    imu_complementary_filter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .angle_valid  (angle_valid),
        .angle_stall  (angle_stall),
        .angle        (angle)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint sat32(input longint v);
        if (v > ANGLE_MAX)
            return ANGLE_MAX;
        if (v < ANGLE_MIN)
            return ANGLE_MIN;
        return v;
    endfunction

    // Vectoring CORDIC: atan2(yin, xin) in degrees with 16 fraction bits.
    function automatic longint accel_angle(input longint yin, input longint xin);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        x = xin * 64'sd1048576;
        y = yin * 64'sd1048576;
        z = 0;
        if (xin == 0 && yin == 0)
            return 0;
        // Rotate a left half plane vector by a quarter turn first.
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = 64'sd90 <<< 24;
            end
            else
            begin
                x = -y;
                y = t;
                z = -(64'sd90 <<< 24);
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_q24[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_q24[i];
            end
        end
        return (z + 128) >>> 8;
    endfunction

    function automatic longint blend_angle(input longint old_a, input longint acc_a);
        longint w;
        w = (blend_q > 65536) ? 64'sd65536 : blend_q;
        return sat32((w * old_a + (64'sd65536 - w) * acc_a + 64'sd32768) >>> 16);
    endfunction

    // Advances the filter state by one sample and returns the expected angles.
    function automatic angle_t predict_angles(input sample_t s);
        longint gx;
        longint gy;
        longint ax;
        longint ay;
        longint az;
        longint mag;
        angle_t r;
        gx = $signed(s.gyro_rate_x);
        gy = $signed(s.gyro_rate_y);
        ax = $signed(s.accel_x);
        ay = $signed(s.accel_y);
        az = $signed(s.accel_z);
        pitch_q = sat32(pitch_q + gx * gyro_scale_q);
        roll_q  = sat32(roll_q - gy * gyro_scale_q);
        mag = (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) + (az < 0 ? -az : az);
        r.accel_applied = 1'b0;
        if (mag > gate_low_q && mag < gate_high_q)
        begin
            pitch_q = blend_angle(pitch_q, accel_angle(ay, az));
            roll_q  = blend_angle(roll_q, accel_angle(ax, az));
            r.accel_applied = 1'b1;
        end
        r.pitch_out = pitch_q[31:0];
        r.roll_out  = roll_q[31:0];
        return r;
    endfunction

    function automatic logic [15:0] spread(input int k);
        int v;
        v = int'($urandom_range(0, 2 * k)) - k;
        return v[15:0];
    endfunction

    function automatic logic [15:0] corner_value();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'hFFFF;
            2:       return 16'h0000;
            3:       return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    // Mostly a sensor near rest with modest rates, some noise and corner values.
    function automatic sample_t random_sample();
        sample_t s;
        int      kind;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            s.gyro_rate_x = spread(2000);
            s.gyro_rate_y = spread(2000);
        end
        else
        begin
            s.gyro_rate_x = 16'($urandom);
            s.gyro_rate_y = 16'($urandom);
        end
        kind = $urandom_range(0, 99);
        if (kind < 65)
        begin
            s.accel_x = spread(9000);
            s.accel_y = spread(9000);
            s.accel_z = spread(20000);
        end
        else if (kind < 85)
        begin
            s.accel_x = 16'($urandom);
            s.accel_y = 16'($urandom);
            s.accel_z = 16'($urandom);
        end
        else
        begin
            s.accel_x = corner_value();
            s.accel_y = corner_value();
            s.accel_z = corner_value();
        end
        return s;
    endfunction

    task automatic add_row(input logic [15:0] gx, gy, ax, ay, az,
                           input logic known, input angle_t want);
        stim_row_t r;
        r = '0;
        r.s.gyro_rate_x = gx;
        r.s.gyro_rate_y = gy;
        r.s.accel_x     = ax;
        r.s.accel_y     = ay;
        r.s.accel_z     = az;
        r.known         = known;
        r.want          = want;
        stim_rows.push_back(r);
    endtask

    task automatic add_cfg(input logic [16:0] gs, bw, gl, gh);
        stim_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.gs     = gs;
        r.bw     = bw;
        r.gl     = gl;
        r.gh     = gh;
        stim_rows.push_back(r);
    endtask

    // Holds the sender off until every outstanding result has been taken.
    task automatic wait_idle();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (angle_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_GYRO_SCALE:   gyro_scale_q = longint'(data[15:0]);
            REG_BLEND_WEIGHT: blend_q = longint'(data);
            REG_GATE_LOW:     gate_low_q = longint'(data);
            REG_GATE_HIGH:    gate_high_q = longint'(data);
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [16:0] gs, bw, gl, gh);
        wait_idle();
        write_reg(REG_GYRO_SCALE, gs);
        write_reg(REG_BLEND_WEIGHT, bw);
        write_reg(REG_GATE_LOW, gl);
        write_reg(REG_GATE_HIGH, gh);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input sample_t s, input logic known, input angle_t want);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            sample_valid <= 1'b0;
        end
        @(negedge clk);
        sample_valid   <= 1'b1;
        sample         <= s;
        row_has_answer = known;
        row_answer     = want;
        do
            @(posedge clk);
        while (sample_stall);
    endtask

    always @(negedge clk)
        angle_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin : monitor
        angle_t want;
        angle_t got;
        if (rst_n)
        begin
            // Check the finished transaction before queueing a newly accepted one.
            if (angle_valid && !angle_stall)
            begin
                got = angle;
                if (angle_q.size() == 0)
                begin
                    $error("angle transaction with no sample outstanding");
                    mismatches++;
                end
                else
                begin
                    want = angle_q.pop_front();
                    if (got.pitch_out !== want.pitch_out)
                    begin
                        $error("pitch_out: expected %0d, got %0d",
                               $signed(want.pitch_out), $signed(got.pitch_out));
                        mismatches++;
                    end
                    if (got.roll_out !== want.roll_out)
                    begin
                        $error("roll_out: expected %0d, got %0d",
                               $signed(want.roll_out), $signed(got.roll_out));
                        mismatches++;
                    end
                    if (got.accel_applied !== want.accel_applied)
                    begin
                        $error("accel_applied: expected %0b, got %0b",
                               want.accel_applied, got.accel_applied);
                        mismatches++;
                    end
                end
            end
            if (sample_valid && !sample_stall)
            begin
                want = predict_angles(sample);
                angle_q.push_back(row_has_answer ? row_answer : want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("imu_complementary_filter test failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   r;
        logic [16:0] gs;
        logic [16:0] bw;
        logic [16:0] gl;
        logic [16:0] gh;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_GYRO_SCALE;
        cfg_data       = '0;
        sample_valid   = 1'b0;
        sample         = '0;
        row_has_answer = 1'b0;
        row_answer     = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        mismatches     = 0;
        cycles         = 0;
        pitch_q        = longint'(RESET_ANGLE_DEG) <<< ANGLE_FRAC_BITS_DEF;
        roll_q         = pitch_q;
        gyro_scale_q   = longint'(GYRO_SCALE_RST);
        blend_q        = longint'(BLEND_WEIGHT_RST);
        gate_low_q     = longint'(GATE_LOW_RST);
        gate_high_q    = longint'(GATE_HIGH_RST);

        // Right after reset: no rotation, no accel, angles stay at 200 degrees.
        add_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                angle_t'{32'sd13107200, 32'sd13107200, 1'b0});
        // Full scale gyro with the widest scale saturates both angles high.
        // Bit 16 of the scale write must be dropped.
        add_cfg(17'h1FFFF, BLEND_WEIGHT_RST, GATE_LOW_RST, GATE_HIGH_RST);
        add_row(16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                angle_t'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0});
        add_row(16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                angle_t'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0});
        add_row(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0);
        add_row(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0);
        add_row(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0);
        add_cfg(17'(GYRO_SCALE_RST), BLEND_WEIGHT_RST, GATE_LOW_RST, GATE_HIGH_RST);
        add_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd16384, 1'b0, '0);
        // Upside down on the axis, then a left half plane vector below the axis.
        add_row(16'd100, -16'sd100, 16'h0000, 16'h0000, -16'sd16384, 1'b0, '0);
        add_row(16'h0000, 16'h0000, -16'sd16384, -16'sd16384, -16'sd1000, 1'b0, '0);
        // One atan2 with both operands zero while the other is not.
        add_row(16'h0000, 16'h0000, 16'd16384, 16'h0000, 16'h0000, 1'b0, '0);
        add_row(16'h0000, 16'h0000, 16'h0000, 16'd16384, 16'h0000, 1'b0, '0);
        // Gate edges are exclusive on both sides.
        add_row(16'h0000, 16'h0000, 16'd8192, 16'h0000, 16'h0000, 1'b0, '0);
        add_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd8193, 1'b0, '0);
        add_row(16'h0000, 16'h0000, 16'h0000, 16'd16384, 16'd16384, 1'b0, '0);
        add_row(16'h0000, 16'h0000, 16'h0000, 16'd16383, 16'd16384, 1'b0, '0);
        add_row(16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0);
        add_row(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0);
        // Weight above one keeps the old angle; the gate spans 0 to 98304, both ends exclusive.
        add_cfg(17'd0, 17'h1FFFF, 17'd0, 17'd98304);
        add_row(16'h0000, 16'h0000, 16'd100, 16'd200, 16'd300, 1'b0, '0);
        add_row(16'd5, 16'd5, 16'h8000, 16'h8000, 16'h7FFF, 1'b0, '0);
        // Zero weight takes the accel angle outright.
        add_cfg(17'd0, 17'd0, 17'd0, 17'd98304);
        add_row(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b0, '0);
        add_row(16'h0000, 16'h0000, -16'sd20000, 16'd12000, -16'sd30000, 1'b0, '0);
        // Inverted gate window never lets the correction in.
        add_cfg(17'd10, 17'd32768, 17'd40000, 17'd1000);
        add_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd16384, 1'b0, '0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_pct  = 15;
        stall_pct = 15;
        foreach (stim_rows[i])
        begin
            r = stim_rows[i];
            if (r.is_cfg)
                program_regs(r.gs, r.bw, r.gl, r.gh);
            else
                send_sample(r.s, r.known, r.want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    gs = 17'(GYRO_SCALE_RST);
                    bw = BLEND_WEIGHT_RST;
                    gl = GATE_LOW_RST;
                    gh = GATE_HIGH_RST;
                end
                1:
                begin
                    gs = 17'd65535;
                    bw = 17'd0;
                    gl = 17'd0;
                    gh = 17'd98304;
                end
                2:
                begin
                    gs = 17'd0;
                    bw = BLEND_ONE;
                    gl = GATE_LOW_RST;
                    gh = GATE_HIGH_RST;
                end
                3:
                begin
                    gs = 17'h1FFFF;
                    bw = 17'h1FFFF;
                    gl = 17'd98304;
                    gh = 17'h1FFFF;
                end
                default:
                begin
                    gs = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 65535))
                                                     : 17'($urandom_range(0, 200));
                    bw = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 131071))
                                                     : 17'($urandom_range(60000, 65536));
                    gl = 17'($urandom_range(0, 16384));
                    gh = 17'(gl + $urandom_range(0, 60000));
                end
            endcase
            program_regs(gs, bw, gl, gh);
            case (ph % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 51; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
                send_sample(random_sample(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("imu_complementary_filter test passed");
        else
            $display("imu_complementary_filter test failed");
        $finish;
    end

endmodule
